>>> rtl/grid_block_sum_normalizer_core_assert.svh
// Assertion macros shared by the grid block sum normalizer RTL.
`ifndef GRID_BLOCK_SUM_NORMALIZER_CORE_ASSERT_SVH
`define GRID_BLOCK_SUM_NORMALIZER_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define GBSN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define GBSN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gbsn_pkg.sv
// Shared constants and types for the grid block sum normalizer.
`default_nettype none

package gbsn_pkg;

    localparam int GRID_DEF    = 9;
    localparam int MAX_DIM_DEF = 1024;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = 22;
    localparam int VAL_W    = 22;
    localparam int ROWCOL_W = 4;

    localparam int SCALE      = 10000;
    localparam int SCALE_W    = 14;
    localparam int DIVIDEND_W = SUM_W + SCALE_W;
    localparam int AREA_W_DEF = 2 * ($clog2(MAX_DIM_DEF) + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Common control for every column cell
    typedef struct packed {
        logic             add_en;
        logic             shift_en;
        logic [PIX_W-1:0] pixel;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/gbsn_pixel_if.sv
// Pixel input channel: valid/ready handshake with one pixel per transfer.
`default_nettype none

interface gbsn_pixel_if import gbsn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/gbsn_cell_if.sv
// Cell result channel: valid/ready handshake with one mesh cell per transfer.
`default_nettype none

interface gbsn_cell_if import gbsn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    cell_value;
    logic [ROWCOL_W-1:0] cell_row;
    logic [ROWCOL_W-1:0] cell_col;
    logic                band_last;

    modport source (output valid, output cell_value, output cell_row, output cell_col,
                    output band_last, input ready);
    modport sink   (input valid, input cell_value, input cell_row, input cell_col,
                    input band_last, output ready);
endinterface

`default_nettype wire

>>> rtl/gbsn_cell.sv
// One column cell: accumulates its pixels and shifts its sum toward the head of the chain.
`default_nettype none

module gbsn_cell import gbsn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctl_t        ctl,
    input  wire logic             hit,
    input  wire logic [SUM_W-1:0] nbr_sum,
    output logic      [SUM_W-1:0] sum
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.shift_en)
        begin
            sum_next = nbr_sum;
        end
        else if (ctl.add_en && hit)
        begin
            // wrap modulo the sum width
            sum_next = sum_reg + SUM_W'(ctl.pixel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> rtl/gbsn_axis.sv
// Splits an image dimension into the base cell length and the count of longer cells.
`default_nettype none

module gbsn_axis import gbsn_pkg::*;
#(
    parameter int GRID    = GRID_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic                              clk,
    input  wire logic [$clog2(MAX_DIM):0]          total,
    output logic      [$clog2(MAX_DIM/GRID+1)-1:0] base,
    output logic      [$clog2(GRID+1)-1:0]         rem
);

    localparam int DIM_W  = $clog2(MAX_DIM) + 1;
    localparam int LEN_W  = $clog2(MAX_DIM / GRID + 1);
    localparam int IDX_W  = $clog2(GRID + 1);
    localparam int SH     = DIM_W + 1;
    localparam int PROD_W = DIM_W + SH;
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << SH) / GRID);

    logic [PROD_W-1:0] recip_prod;
    logic [LEN_W-1:0]  q0_reg;
    logic [LEN_W-1:0]  q0_next;
    logic [DIM_W-1:0]  tot_reg;
    logic [DIM_W-1:0]  back_prod;
    logic [DIM_W-1:0]  resid;
    logic              fix;
    logic [LEN_W-1:0]  base_reg;
    logic [LEN_W-1:0]  base_next;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;

    // Stage 1: quotient estimate, at most one short of the true value
    always_comb
    begin
        recip_prod = PROD_W'(total) * RECIP;
        q0_next    = LEN_W'(recip_prod[PROD_W-1:SH]);
    end

    // Stage 2: correct the estimate with one compare and subtract
    always_comb
    begin
        back_prod = DIM_W'(q0_reg) * DIM_W'(GRID);
        resid     = tot_reg - back_prod;
        fix       = resid >= DIM_W'(GRID);
        base_next = fix ? q0_reg + LEN_W'(1) : q0_reg;
        rem_next  = fix ? IDX_W'(resid - DIM_W'(GRID)) : IDX_W'(resid);
    end

    always_ff @(posedge clk)
    begin
        q0_reg   <= q0_next;
        tot_reg  <= total;
        base_reg <= base_next;
        rem_reg  <= rem_next;
    end

    assign base = base_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/gbsn_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module gbsn_div import gbsn_pkg::*;
#(
    parameter int DVD_W = DIVIDEND_W,
    parameter int DVS_W = AREA_W_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DVD_W-1:0] dq_reg;
    logic [DVD_W-1:0] dq_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift the dividend out the top, the quotient bit in at the bottom
            cnt_next = cnt_reg - CNT_W'(1);
            dq_next  = {dq_reg[DVD_W-2:0], ge};
            rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = cnt_reg == CNT_W'(1);
    assign quotient = dq_reg;

endmodule

`default_nettype wire

>>> rtl/grid_block_sum_normalizer_core.sv
// Grid block sum normalizer. Pixels arrive in raster order, one per transfer, and are taken
// at one per cycle while a band of rows accumulates into a chain of GRID column cells. The
// transfer that carries a band's last pixel starts an unload: the chain shifts one cell sum
// per step into a shared radix-2 divider that forms sum*10000/(width*height). Each cell goes
// through a shift step, the divide and a put step, held longer if the result side stalls; no
// pixel is taken during that unload. The last result of a band sits in the output register
// while pixels of the next band flow in. After reset and after every configuration write the
// pixel input holds off while the cell length split of width and height is recomputed.
`default_nettype none

`include "grid_block_sum_normalizer_core_assert.svh"

module grid_block_sum_normalizer_core import gbsn_pkg::*;
#(
    parameter int GRID    = GRID_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    gbsn_pixel_if.sink                pix,
    gbsn_cell_if.source               cells
);

    localparam int IDX_W  = $clog2(GRID + 1);
    localparam int PCOL_W = $clog2(MAX_DIM);
    localparam int DIM_W  = PCOL_W + 1;
    localparam int LEN_W  = $clog2(MAX_DIM / GRID + 1);
    localparam int AREA_W = 2 * DIM_W;

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_PUT = 2'd3;

    localparam logic [1:0] SETTLE = 2'd2;
    localparam logic [DIVIDEND_W-1:0] SCALE_V = DIVIDEND_W'(SCALE);

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [1:0]       settle_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    // Raster position
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [PCOL_W-1:0] pixel_col_reg;
    logic [PCOL_W-1:0] pixel_col_next;
    logic [IDX_W-1:0]  col_idx_reg;
    logic [IDX_W-1:0]  col_idx_next;
    logic [LEN_W-1:0]  col_in_cell_reg;
    logic [LEN_W-1:0]  col_in_cell_next;
    logic [IDX_W-1:0]  band_idx_reg;
    logic [IDX_W-1:0]  band_idx_next;
    logic [LEN_W-1:0]  row_in_band_reg;
    logic [LEN_W-1:0]  row_in_band_next;
    logic [IDX_W-1:0]  drain_cnt_reg;
    logic [IDX_W-1:0]  drain_cnt_next;
    logic [IDX_W-1:0]  drain_band_reg;
    logic [IDX_W-1:0]  drain_band_next;

    logic [LEN_W-1:0] base_w;
    logic [IDX_W-1:0] rem_w;
    logic [LEN_W-1:0] base_h;
    logic [IDX_W-1:0] rem_h;

    logic             in_xfer;
    logic             col_hit;
    logic [LEN_W:0]   len_w;
    logic [LEN_W:0]   cin_inc;
    logic             cell_done;
    logic [DIM_W-1:0] pcol_inc;
    logic             row_end;
    logic [LEN_W:0]   len_h;
    logic [LEN_W:0]   rib_inc;
    logic             band_end;

    // Cell chain and divider
    cell_ctl_t              ctl;
    logic [SUM_W-1:0]       cell_sum [GRID];
    logic                   sums_zero;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_quot;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [AREA_W-1:0]      area;
    logic                   put_ok;
    logic                   drain_last;

    // Output register
    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [ROWCOL_W-1:0] out_row_reg;
    logic [ROWCOL_W-1:0] out_col_reg;
    logic                out_last_reg;

    // Effective sizes: width clamped to [1, MAX_DIM], height to [GRID, MAX_DIM]
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if (int'(width_reg) > MAX_DIM)
        begin
            eff_w = DIM_W'(MAX_DIM);
        end
        else
        begin
            eff_w = DIM_W'(width_reg);
        end

        if (int'(height_reg) < GRID)
        begin
            eff_h = DIM_W'(GRID);
        end
        else if (int'(height_reg) > MAX_DIM)
        begin
            eff_h = DIM_W'(MAX_DIM);
        end
        else
        begin
            eff_h = DIM_W'(height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
            settle_reg <= SETTLE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
            settle_reg <= SETTLE;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    gbsn_axis #(.GRID(GRID), .MAX_DIM(MAX_DIM)) u_axis_w
    (
        .clk   (clk),
        .total (eff_w),
        .base  (base_w),
        .rem   (rem_w)
    );

    gbsn_axis #(.GRID(GRID), .MAX_DIM(MAX_DIM)) u_axis_h
    (
        .clk   (clk),
        .total (eff_h),
        .base  (base_h),
        .rem   (rem_h)
    );

    assign pix.ready = (state_reg == ST_ACC) && (settle_reg == 2'd0);
    assign in_xfer   = pix.valid && pix.ready;

    // Position arithmetic for the pixel in flight
    always_comb
    begin
        col_hit   = col_idx_reg < IDX_W'(GRID);
        len_w     = (LEN_W+1)'(base_w) + (LEN_W+1)'(col_idx_reg < rem_w);
        cin_inc   = (LEN_W+1)'(col_in_cell_reg) + (LEN_W+1)'(1);
        cell_done = cin_inc >= len_w;
        pcol_inc  = DIM_W'(pixel_col_reg) + DIM_W'(1);
        row_end   = pcol_inc >= eff_w;
        len_h     = (LEN_W+1)'(base_h) + (LEN_W+1)'(band_idx_reg < rem_h);
        rib_inc   = (LEN_W+1)'(row_in_band_reg) + (LEN_W+1)'(1);
        band_end  = row_end && (rib_inc >= len_h);
    end

    assign put_ok     = !out_valid_reg || cells.ready;
    assign drain_last = drain_cnt_reg == IDX_W'(GRID - 1);

    always_comb
    begin
        state_next       = state_reg;
        pixel_col_next   = pixel_col_reg;
        col_idx_next     = col_idx_reg;
        col_in_cell_next = col_in_cell_reg;
        band_idx_next    = band_idx_reg;
        row_in_band_next = row_in_band_reg;
        drain_cnt_next   = drain_cnt_reg;
        drain_band_next  = drain_band_reg;

        case (state_reg)
            ST_ACC:
            begin
                if (in_xfer)
                begin
                    if (col_hit)
                    begin
                        if (cell_done)
                        begin
                            col_idx_next     = col_idx_reg + IDX_W'(1);
                            col_in_cell_next = '0;
                        end
                        else
                        begin
                            col_in_cell_next = cin_inc[LEN_W-1:0];
                        end
                    end

                    if (row_end)
                    begin
                        pixel_col_next   = '0;
                        col_idx_next     = '0;
                        col_in_cell_next = '0;
                        if (band_end)
                        begin
                            row_in_band_next = '0;
                            band_idx_next    = (band_idx_reg == IDX_W'(GRID - 1)) ?
                                               '0 : band_idx_reg + IDX_W'(1);
                            drain_cnt_next   = '0;
                            drain_band_next  = band_idx_reg;
                            state_next       = ST_MUL;
                        end
                        else
                        begin
                            row_in_band_next = rib_inc[LEN_W-1:0];
                        end
                    end
                    else
                    begin
                        pixel_col_next = pcol_inc[PCOL_W-1:0];
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (put_ok)
                begin
                    if (drain_last)
                    begin
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        drain_cnt_next = drain_cnt_reg + IDX_W'(1);
                        state_next     = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_ACC;
            pixel_col_reg   <= '0;
            col_idx_reg     <= '0;
            col_in_cell_reg <= '0;
            band_idx_reg    <= '0;
            row_in_band_reg <= '0;
            drain_cnt_reg   <= '0;
            drain_band_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_col_reg   <= pixel_col_next;
            col_idx_reg     <= col_idx_next;
            col_in_cell_reg <= col_in_cell_next;
            band_idx_reg    <= band_idx_next;
            row_in_band_reg <= row_in_band_next;
            drain_cnt_reg   <= drain_cnt_next;
            drain_band_reg  <= drain_band_next;
        end
    end

    // Column cell chain: the head feeds the divider, the tail takes in zero
    assign ctl.add_en   = in_xfer;
    assign ctl.shift_en = state_reg == ST_MUL;
    assign ctl.pixel    = pix.pixel;

    for (genvar i = 0; i < GRID; i++)
    begin : g_cell
        logic [SUM_W-1:0] nbr;

        if (i == GRID - 1)
        begin : g_tail
            assign nbr = '0;
        end
        else
        begin : g_link
            assign nbr = cell_sum[i+1];
        end

        gbsn_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .hit     (col_idx_reg == IDX_W'(i)),
            .nbr_sum (nbr),
            .sum     (cell_sum[i])
        );
    end

    always_comb
    begin
        sums_zero = 1'b1;
        for (int k = 0; k < GRID; k++)
        begin
            if (cell_sum[k] != '0)
            begin
                sums_zero = 1'b0;
            end
        end
    end

    assign dividend = DIVIDEND_W'(cell_sum[0]) * SCALE_V;
    assign area     = AREA_W'(eff_w) * AREA_W'(eff_h);

    gbsn_div #(.DVD_W(DIVIDEND_W), .DVS_W(AREA_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL),
        .dividend (dividend),
        .divisor  (area),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Output register: load when empty or when the held result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_PUT) && put_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cells.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PUT) && put_ok)
        begin
            out_value_reg <= div_quot[VAL_W-1:0];
            out_row_reg   <= ROWCOL_W'(drain_band_reg);
            out_col_reg   <= ROWCOL_W'(drain_cnt_reg);
            out_last_reg  <= drain_last;
        end
    end

    assign cells.valid      = out_valid_reg;
    assign cells.cell_value = out_value_reg;
    assign cells.cell_row   = out_row_reg;
    assign cells.cell_col   = out_col_reg;
    assign cells.band_last  = out_last_reg;

    `GBSN_ASSERT_NEXT(a_band_start, in_xfer && band_end,
        (state_reg == ST_MUL) && (drain_cnt_reg == '0), "band end did not start unload")
    `GBSN_ASSERT_NOW(a_div_done_state, div_done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `GBSN_ASSERT_NOW(a_drain_range, state_reg != ST_ACC, drain_cnt_reg < IDX_W'(GRID),
        "unload counter past the last cell")
    `GBSN_ASSERT_NEXT(a_chain_clear, (state_reg == ST_PUT) && put_ok && drain_last,
        sums_zero, "column sums not cleared after unload")
    `GBSN_ASSERT_NOW(a_last_flag, out_valid_reg,
        out_last_reg == (out_col_reg == ROWCOL_W'(GRID - 1)), "band_last on wrong cell")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for grid_block_sum_normalizer_core: mesh cell results predicted per pixel.
`timescale 1ns / 1ps

module testbench import gbsn_pkg::*;;

    localparam int GRID          = GRID_DEF;
    localparam int MAX_DIM       = MAX_DIM_DEF;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 50;
    localparam int DRAIN_CYCLES  = 400;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_ITEMS  = 160;
    localparam int BAND_CAP      = 300;
    localparam int LIMIT_CYCLES  = 10_000_000;
    localparam int PRINT_CAP     = 100;

    typedef struct {
        logic [VAL_W-1:0]    value;
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
        logic                last;
    } cell_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gbsn_pixel_if pix ();
    gbsn_cell_if  cells ();

    grid_block_sum_normalizer_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix          (pix),
        .cells        (cells)
    );

    // Predictor copy of the sizes and the band accumulation state
    logic [CFG_W-1:0] img_width;
    logic [CFG_W-1:0] img_height;
    logic [SUM_W-1:0] col_sum [GRID];
    logic [9:0]       pix_col;
    logic [3:0]       cell_idx;
    logic [6:0]       cell_pos;
    logic [3:0]       band;
    logic [6:0]       band_row;

    cell_result_t pending_cells [$];
    int           mismatches;
    int           cycle_count;
    bit           no_idle;
    logic         hold_request;
    logic         hold_active;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_width();
        if (img_width < 1)
            return 1;
        if (img_width > MAX_DIM)
            return MAX_DIM;
        return img_width;
    endfunction

    function automatic int unsigned eff_height();
        if (img_height < GRID)
            return GRID;
        if (img_height > MAX_DIM)
            return MAX_DIM;
        return img_height;
    endfunction

    function automatic int unsigned cell_len(input int unsigned idx, input int unsigned total);
        return total / GRID + ((idx < total % GRID) ? 1 : 0);
    endfunction

    function automatic void reset_model();
        img_width  = CFG_RESET;
        img_height = CFG_RESET;
        for (int c = 0; c < GRID; c++)
            col_sum[c] = '0;
        pix_col  = '0;
        cell_idx = '0;
        cell_pos = '0;
        band     = '0;
        band_row = '0;
    endfunction

    // Add one pixel to the band; on the band's last pixel queue its GRID cells.
    function automatic void accumulate_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      next_val;
        longint unsigned  area;
        longint unsigned  scaled;
        cell_result_t     res;
        w = eff_width();
        h = eff_height();
        if (cell_idx < GRID)
        begin
            col_sum[cell_idx] = col_sum[cell_idx] + SUM_W'(px);
            next_val = cell_pos + 1;
            if (next_val >= cell_len(cell_idx, w))
            begin
                cell_idx = cell_idx + 1'b1;
                cell_pos = '0;
            end
            else
                cell_pos = 7'(next_val);
        end
        next_val = pix_col + 1;
        if (next_val < w)
        begin
            pix_col = 10'(next_val);
            return;
        end
        pix_col  = '0;
        cell_idx = '0;
        cell_pos = '0;
        next_val = band_row + 1;
        if (next_val < cell_len(band, h))
        begin
            band_row = 7'(next_val);
            return;
        end
        area = longint'(w) * longint'(h);
        for (int c = 0; c < GRID; c++)
        begin
            scaled    = col_sum[c];
            scaled    = scaled * SCALE / area;
            res.value = VAL_W'(scaled);
            res.row   = band;
            res.col   = ROWCOL_W'(c);
            res.last  = (c == GRID - 1);
            pending_cells.push_back(res);
            col_sum[c] = '0;
        end
        band_row = '0;
        band     = (band + 1 >= GRID) ? '0 : band + 1'b1;
    endfunction

    function automatic int pixels_to_band_end();
        int unsigned w;
        int unsigned h;
        int unsigned len;
        int unsigned row_left;
        w   = eff_width();
        h   = eff_height();
        len = cell_len(band, h);
        row_left = (pix_col >= w) ? 1 : w - pix_col;
        if (band_row + 1 >= len)
            return row_left;
        return row_left + (len - band_row - 1) * w;
    endfunction

    function automatic logic [PIX_W-1:0] edge_pixel(input int i);
        case (i % 8)
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'hFE;
            4: return 8'h80;
            5: return 8'h7F;
            6: return 8'h55;
            default: return 8'hAA;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: cell check: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_cell();
        cell_result_t want;
        if (pending_cells.size() == 0)
        begin
            report_mismatch($sformatf("unexpected cell row %0d col %0d value %0d",
                                      cells.cell_row, cells.cell_col, cells.cell_value));
            return;
        end
        want = pending_cells.pop_front();
        if (cells.cell_value !== want.value)
            report_mismatch($sformatf("row %0d col %0d value %0d, want %0d",
                                      want.row, want.col, cells.cell_value, want.value));
        if (cells.cell_row !== want.row)
            report_mismatch($sformatf("cell_row %0d, want %0d", cells.cell_row, want.row));
        if (cells.cell_col !== want.col)
            report_mismatch($sformatf("row %0d cell_col %0d, want %0d",
                                      want.row, cells.cell_col, want.col));
        if (cells.band_last !== want.last)
            report_mismatch($sformatf("row %0d col %0d band_last %0b, want %0b",
                                      want.row, want.col, cells.band_last, want.last));
    endtask

    always @(posedge clk)
        if (rst_n && cells.valid === 1'b1 && cells.ready === 1'b1)
            check_cell();

    // Result side: random stalls, or a long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_active)
                cells.ready <= 1'b0;
            else if (stall > 0)
            begin
                cells.ready <= 1'b0;
                stall--;
            end
            else
            begin
                cells.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = idle_gap();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_active)
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active  <= 1'b0;
                hold_request <= 1'b0;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= value;
        do
            @(posedge clk);
        while (pix.ready !== 1'b1);
        accumulate_pixel(value);
    endtask

    task automatic send_to_band_end(input bit edges);
        int n;
        n = pixels_to_band_end();
        for (int i = 0; i < n; i++)
            send_pixel(edges ? edge_pixel(i) : PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    // Drop valid, let every queued cell arrive, then let the block settle.
    task automatic wait_idle(input int settle);
        pix.valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_size(input bit write_w, input int unsigned w,
                            input bit write_h, input int unsigned h);
        if (write_w)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= REG_IMAGE_WIDTH;
            cfg_data     <= CFG_W'(w);
            @(posedge clk);
            img_width = CFG_W'(w);
        end
        if (write_h)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= REG_IMAGE_HEIGHT;
            cfg_data     <= CFG_W'(h);
            @(posedge clk);
            img_height = CFG_W'(h);
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic test_reset_size();
        send_to_band_end(1'b1);
    endtask

    task automatic test_pixel_extremes();
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 9, 1'b1, 9);
        send_to_band_end(1'b1);
        send_to_band_end(1'b1);
    endtask

    task automatic test_clamped_sizes();
        // zero width acts as one, zero height as GRID; trailing columns stay empty
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 0, 1'b1, 0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 2047, 1'b1, 2047);
        send_random(20);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 1, 1'b0, 0);
        send_to_band_end(1'b0);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 1, 1'b1, MAX_DIM);
        repeat (2) send_pixel(8'hFF);
        send_to_band_end(1'b0);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, MAX_DIM, 1'b1, GRID);
        send_to_band_end(1'b0);
    endtask

    task automatic test_mid_image_changes();
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 1, 1'b1, 9);
        send_random(1);
        wait_idle(SETTLE_CYCLES);
        // widen after the last cell column fills: the rest of the row is dropped
        set_size(1'b1, 9, 1'b0, 0);
        send_random(8);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 12, 1'b0, 0);
        send_random(4);
        // shrink below the current position: the row closes on the next pixel
        send_random(5);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 3, 1'b0, 0);
        send_random(1);
        // shrink the height past the rows already in the band
        wait_idle(SETTLE_CYCLES);
        set_size(1'b0, 0, 1'b1, 40);
        send_random(9);
        wait_idle(SETTLE_CYCLES);
        set_size(1'b0, 0, 1'b1, 9);
        send_random(3);
    endtask

    task automatic test_output_backpressure();
        wait_idle(SETTLE_CYCLES);
        set_size(1'b1, 3, 1'b1, 9);
        no_idle = 1'b1;
        hold_request <= 1'b1;
        send_random(45);
        no_idle = 1'b0;
    endtask

    function automatic int unsigned random_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 16);
        if (r < 95)
            return $urandom_range(17, 48);
        return $urandom_range(0, 2047);
    endfunction

    function automatic int unsigned random_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(9, 18);
        if (r < 90)
            return $urandom_range(0, 8);
        return $urandom_range(19, 2047);
    endfunction

    task automatic test_random_stream();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle(SETTLE_CYCLES);
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: set_size(1'b1, random_width(), 1'b1, random_height());
                1: set_size(1'b1, random_width(), 1'b0, 0);
                2: set_size(1'b0, 0, 1'b1, random_height());
                default: ;
            endcase
            if ($urandom_range(0, 9) < 7 && pixels_to_band_end() <= BAND_CAP)
            begin
                // whole bands with random content
                repeat ($urandom_range(1, 3))
                begin
                    n = pixels_to_band_end();
                    if (n > BAND_CAP)
                        break;
                    send_random(n);
                    sent += n;
                end
            end
            else
            begin
                n = $urandom_range(1, 40);
                send_random(n);
                sent += n;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        pix.valid    = 1'b0;
        pix.pixel    = '0;
        cells.ready  = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        hold_request = 1'b0;
        hold_active  = 1'b0;
        no_idle      = 1'b0;
        mismatches   = 0;
        reset_model();
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_pixel_extremes();
        test_clamped_sizes();
        test_mid_image_changes();
        test_output_backpressure();
        test_random_stream();

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
